FILE: sv/hpd_pkg.sv
// Shared constants, codes and slot arithmetic for the HPACK dynamic header table.
`timescale 1ns / 1ps
package hpd_pkg;
	localparam int RING_DEPTH     = 512;
	localparam int ENTRY_OVERHEAD = 32;
	localparam int STATIC_ENTRIES = 61;
	localparam int SLOT_W         = $clog2(RING_DEPTH);
	localparam int CNT_W          = $clog2(RING_DEPTH + 1);
	localparam int SLOT_SUM_W     = SLOT_W + 1;
	localparam int SIZE_W         = 18;
	localparam int TAG_W          = 16;
	localparam int LEN_W          = 16;
	localparam int IDX_W          = 16;
	localparam int BYTES_W        = 32;
	localparam int COUNT_W        = 10;
	localparam logic [BYTES_W-1:0] DEFAULT_LIMIT = 32'd4096;

	localparam logic [1:0] REQ_ADD    = 2'd0;
	localparam logic [1:0] REQ_LOOKUP = 2'd1;
	localparam logic [1:0] REQ_RESIZE = 2'd2;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_FULL    = 2'd1;
	localparam logic [1:0] ST_CLEARED = 2'd2;
	localparam logic [1:0] ST_MISS    = 2'd3;

	function automatic logic [SLOT_W-1:0] slot_add(input logic [SLOT_W-1:0] a,
		input logic [SLOT_W-1:0] b);
		logic [SLOT_SUM_W-1:0] sum;
		sum = {1'b0, a} + {1'b0, b};
		if (sum >= SLOT_SUM_W'(RING_DEPTH)) begin
			sum = sum - SLOT_SUM_W'(RING_DEPTH);
		end
		return sum[SLOT_W-1:0];
	endfunction

	function automatic logic [SLOT_W-1:0] slot_dec(input logic [SLOT_W-1:0] a);
		logic [SLOT_W-1:0] r;
		if (a == '0) begin
			r = SLOT_W'(RING_DEPTH - 1);
		end else begin
			r = a - SLOT_W'(1);
		end
		return r;
	endfunction
endpackage

FILE: sv/hpack_dynamic_table_top.sv
// HPACK dynamic header table: ring of tags and entry sizes with eviction sequencer.
// A refused, oversized, missed or unknown request is answered from the decode state;
// a lookup hit goes on to the read state, and an add or a size update to the evict
// state, which reads the size memory once per evicted entry in the evict-wait loop.
// One request at a time; a new request may be accepted while done is shown.
// Reset empties the table and sets the limit to 4096; the memories are not cleared.
`timescale 1ns / 1ps
module hpack_dynamic_table_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [1:0]                    req_type,
	input  logic [hpd_pkg::LEN_W-1:0]     name_len,
	input  logic [hpd_pkg::LEN_W-1:0]     value_len,
	input  logic [hpd_pkg::TAG_W-1:0]     entry_tag,
	input  logic [hpd_pkg::IDX_W-1:0]     lookup_index,
	input  logic [hpd_pkg::BYTES_W-1:0]   limit_next,
	output logic                          done,
	output logic [1:0]                    status,
	output logic [hpd_pkg::TAG_W-1:0]     found_tag,
	output logic [hpd_pkg::COUNT_W-1:0]   entry_count,
	output logic [hpd_pkg::BYTES_W-1:0]   used_size
);
	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_DEC   = 3'd1;
	localparam logic [2:0] S_EVICT = 3'd2;
	localparam logic [2:0] S_EWAIT = 3'd3;
	localparam logic [2:0] S_LRD   = 3'd4;

	logic [2:0]                        state_q;
	logic [1:0]                        req_q;
	logic [hpd_pkg::SIZE_W-1:0]        esize_q;
	logic [hpd_pkg::TAG_W-1:0]         tag_q;
	logic [hpd_pkg::IDX_W-1:0]         vindex_q;
	logic [hpd_pkg::BYTES_W-1:0]       target_q;
	logic [hpd_pkg::SLOT_W-1:0]        newest_q;
	logic [hpd_pkg::CNT_W-1:0]         lc_q;
	logic [hpd_pkg::BYTES_W-1:0]       tb_q;
	logic [hpd_pkg::BYTES_W-1:0]       limit_q;
	logic                              done_q;
	logic [1:0]                        status_q;
	logic [hpd_pkg::TAG_W-1:0]         found_q;
	logic [hpd_pkg::COUNT_W-1:0]       count_q;
	logic [hpd_pkg::BYTES_W-1:0]       used_q;

	logic [hpd_pkg::TAG_W-1:0]         tag_mem [hpd_pkg::RING_DEPTH];
	logic [hpd_pkg::SIZE_W-1:0]        size_mem [hpd_pkg::RING_DEPTH];
	logic [hpd_pkg::TAG_W-1:0]         tag_rd_q;
	logic [hpd_pkg::SIZE_W-1:0]        size_rd_q;

	logic [hpd_pkg::IDX_W-1:0]         age;
	logic                              lookup_hit;
	logic                              evict_more;
	logic [hpd_pkg::CNT_W-1:0]         lc_m1;
	logic [hpd_pkg::SLOT_W-1:0]        rd_slot;
	logic                              wr_en;
	logic [hpd_pkg::SLOT_W-1:0]        wr_slot;
	logic [hpd_pkg::BYTES_W-1:0]       tb_fin;
	logic [hpd_pkg::BYTES_W-1:0]       esize_ext;

	assign busy        = (state_q != S_IDLE);
	assign done        = done_q;
	assign status      = status_q;
	assign found_tag   = found_q;
	assign entry_count = count_q;
	assign used_size   = used_q;

	always_comb begin
		age        = vindex_q - hpd_pkg::IDX_W'(hpd_pkg::STATIC_ENTRIES + 1);
		lookup_hit = (vindex_q > hpd_pkg::IDX_W'(hpd_pkg::STATIC_ENTRIES))
			&& (age < hpd_pkg::IDX_W'(lc_q));
		evict_more = (tb_q > target_q) && (lc_q != '0);
		lc_m1      = lc_q - hpd_pkg::CNT_W'(1);
		if (state_q == S_EVICT) begin
			rd_slot = hpd_pkg::slot_add(newest_q, lc_m1[hpd_pkg::SLOT_W-1:0]);
		end else begin
			rd_slot = hpd_pkg::slot_add(newest_q, age[hpd_pkg::SLOT_W-1:0]);
		end
		wr_slot   = hpd_pkg::slot_dec(newest_q);
		wr_en     = (state_q == S_EVICT) && !evict_more && (req_q == hpd_pkg::REQ_ADD);
		tb_fin    = (lc_q == '0) ? '0 : tb_q;
		esize_ext = hpd_pkg::BYTES_W'(esize_q);
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			tag_mem[wr_slot]  <= tag_q;
			size_mem[wr_slot] <= esize_q;
		end
		tag_rd_q  <= tag_mem[rd_slot];
		size_rd_q <= size_mem[rd_slot];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			newest_q <= '0;
			lc_q     <= '0;
			tb_q     <= '0;
			limit_q  <= hpd_pkg::DEFAULT_LIMIT;
			done_q   <= 1'b0;
			status_q <= hpd_pkg::ST_OK;
			found_q  <= '0;
			count_q  <= '0;
			used_q   <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						req_q    <= req_type;
						esize_q  <= hpd_pkg::SIZE_W'({1'b0, name_len} + {1'b0, value_len})
							+ hpd_pkg::SIZE_W'(hpd_pkg::ENTRY_OVERHEAD);
						tag_q    <= entry_tag;
						vindex_q <= lookup_index;
						target_q <= limit_next;
						state_q  <= S_DEC;
					end
				end
				S_DEC: begin
					case (req_q)
						hpd_pkg::REQ_ADD: begin
							if (lc_q >= hpd_pkg::CNT_W'(hpd_pkg::RING_DEPTH)) begin
								status_q <= hpd_pkg::ST_FULL;
								found_q  <= '0;
								count_q  <= hpd_pkg::COUNT_W'(lc_q);
								used_q   <= tb_q;
								done_q   <= 1'b1;
								state_q  <= S_IDLE;
							end else if (esize_ext > limit_q) begin
								lc_q     <= '0;
								tb_q     <= '0;
								status_q <= hpd_pkg::ST_CLEARED;
								found_q  <= '0;
								count_q  <= '0;
								used_q   <= '0;
								done_q   <= 1'b1;
								state_q  <= S_IDLE;
							end else begin
								target_q <= limit_q - esize_ext;
								state_q  <= S_EVICT;
							end
						end
						hpd_pkg::REQ_LOOKUP: begin
							if (lookup_hit) begin
								state_q <= S_LRD;
							end else begin
								status_q <= hpd_pkg::ST_MISS;
								found_q  <= '0;
								count_q  <= hpd_pkg::COUNT_W'(lc_q);
								used_q   <= tb_q;
								done_q   <= 1'b1;
								state_q  <= S_IDLE;
							end
						end
						hpd_pkg::REQ_RESIZE: begin
							state_q <= S_EVICT;
						end
						default: begin
							status_q <= hpd_pkg::ST_OK;
							found_q  <= '0;
							count_q  <= hpd_pkg::COUNT_W'(lc_q);
							used_q   <= tb_q;
							done_q   <= 1'b1;
							state_q  <= S_IDLE;
						end
					endcase
				end
				S_EVICT: begin
					if (evict_more) begin
						state_q <= S_EWAIT;
					end else begin
						status_q <= hpd_pkg::ST_OK;
						found_q  <= '0;
						done_q   <= 1'b1;
						state_q  <= S_IDLE;
						if (req_q == hpd_pkg::REQ_ADD) begin
							newest_q <= wr_slot;
							lc_q     <= lc_q + hpd_pkg::CNT_W'(1);
							tb_q     <= tb_fin + esize_ext;
							count_q  <= hpd_pkg::COUNT_W'(lc_q + hpd_pkg::CNT_W'(1));
							used_q   <= tb_fin + esize_ext;
						end else begin
							limit_q <= target_q;
							tb_q    <= tb_fin;
							count_q <= hpd_pkg::COUNT_W'(lc_q);
							used_q  <= tb_fin;
						end
					end
				end
				S_EWAIT: begin
					lc_q    <= lc_m1;
					tb_q    <= (hpd_pkg::BYTES_W'(size_rd_q) > tb_q) ? '0
						: tb_q - hpd_pkg::BYTES_W'(size_rd_q);
					state_q <= S_EVICT;
				end
				S_LRD: begin
					status_q <= hpd_pkg::ST_OK;
					found_q  <= tag_rd_q;
					count_q  <= hpd_pkg::COUNT_W'(lc_q);
					used_q   <= tb_q;
					done_q   <= 1'b1;
					state_q  <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		lc_q <= hpd_pkg::CNT_W'(hpd_pkg::RING_DEPTH))
		else $error("Live entry count exceeds the ring depth.");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy && !done))
		else $error("Accepted request did not make the block busy.");

	a_empty_size: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (entry_count != '0 || used_size == '0))
		else $error("Empty table reported a non-zero size.");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == hpd_pkg::ST_FULL)
			|-> (entry_count == hpd_pkg::COUNT_W'(hpd_pkg::RING_DEPTH)))
		else $error("Full status reported with a ring that is not full.");

	a_evict_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EWAIT) |-> (lc_q != '0))
		else $error("Eviction attempted on an empty table.");
endmodule
